@@ hdl/i2cmts_pkg.sv @@
`timescale 1ns / 1ps

package i2cmts_pkg;

  localparam int COUNT_BITS_DEF = 8;

  localparam logic       ACT_START = 1'b0;
  localparam logic       ACT_EVENT = 1'b1;

  localparam logic       ADDR_READ_BIT  = 1'b1;
  localparam logic       ADDR_WRITE_BIT = 1'b0;

  localparam logic [3:0] CMD_NONE  = 4'h0;
  localparam logic [3:0] CMD_RUN   = 4'h1;
  localparam logic [3:0] CMD_START = 4'h2;
  localparam logic [3:0] CMD_STOP  = 4'h4;
  localparam logic [3:0] CMD_ACK   = 4'h8;

  localparam logic [2:0] ST_DONE      = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK = 3'd1;
  localparam logic [2:0] ST_DATA_NACK = 3'd2;
  localparam logic [2:0] ST_BUS_ERR   = 3'd3;
  localparam logic [2:0] ST_ARB_LOST  = 3'd4;

  typedef struct packed {
    logic       action;
    logic [6:0] target_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [7:0] next_write_byte;
    logic       bus_error;
    logic       arbitration_lost;
    logic       address_nack;
    logic       data_nack;
    logic [7:0] received_byte;
  } in_word_t;

  typedef struct packed {
    logic       command_valid;
    logic [3:0] command_bits;
    logic       address_valid;
    logic [7:0] address_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] read_total;
    logic       controller_reset;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

@@ hdl/i2cmts_in_reg.sv @@
`timescale 1ns / 1ps

module i2cmts_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cmts_pkg::in_word_t in_word,
  input  logic                 down_ready,
  output i2cmts_pkg::hs_t      hs,
  output i2cmts_pkg::in_word_t word_r
);

  logic valid_r;
  logic valid_nxt;

  assign in_ready  = !valid_r || down_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  assign hs.valid = valid_r;
  assign hs.ready = down_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= in_word;
    end
  end

endmodule

@@ hdl/i2cmts_core.sv @@
`timescale 1ns / 1ps

module i2cmts_core #(
  parameter int COUNT_BITS = i2cmts_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  i2cmts_pkg::in_word_t  word,
  output i2cmts_pkg::out_word_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WCONT,
    PH_WFIN,
    PH_RSTART,
    PH_RCONT,
    PH_RFIN
  } phase_t;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_ONE = COUNT_BITS'(1);

  phase_t     phase_r, phase_nxt;
  logic [6:0] slave_address_r, slave_address_nxt;
  cnt_t       writes_left_r, writes_left_nxt;
  cnt_t       reads_left_r, reads_left_nxt;
  cnt_t       reads_done_r, reads_done_nxt;

  always_comb begin
    cnt_t wl;
    cnt_t rl;
    cnt_t rd;
    logic [3:0] extra;
    phase_nxt         = phase_r;
    slave_address_nxt = slave_address_r;
    writes_left_nxt   = writes_left_r;
    reads_left_nxt    = reads_left_r;
    reads_done_nxt    = reads_done_r;
    res               = '0;
    wl                = '0;
    rl                = '0;
    rd                = '0;
    extra             = i2cmts_pkg::CMD_NONE;

    if (word.action == i2cmts_pkg::ACT_START) begin
      slave_address_nxt = word.target_address;
      wl                = COUNT_BITS'(word.write_count);
      rl                = COUNT_BITS'(word.read_count);
      reads_done_nxt    = '0;
      reads_left_nxt    = rl;
      if (wl != '0) begin
        res.address_valid = 1'b1;
        res.address_byte  = {word.target_address, i2cmts_pkg::ADDR_WRITE_BIT};
        res.data_valid    = 1'b1;
        res.data_byte     = word.next_write_byte;
        wl                = wl - CNT_ONE;
        writes_left_nxt   = wl;
        res.command_valid = 1'b1;
        if (wl != '0) begin
          res.command_bits = i2cmts_pkg::CMD_RUN | i2cmts_pkg::CMD_START;
          phase_nxt        = PH_WCONT;
        end else if (rl == '0) begin
          res.command_bits = i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN
                           | i2cmts_pkg::CMD_START;
          phase_nxt        = PH_WFIN;
        end else begin
          res.command_bits = i2cmts_pkg::CMD_RUN | i2cmts_pkg::CMD_START;
          phase_nxt        = PH_RSTART;
        end
      end else if (rl != '0) begin
        writes_left_nxt   = wl;
        res.address_valid = 1'b1;
        res.address_byte  = {word.target_address, i2cmts_pkg::ADDR_READ_BIT};
        res.command_valid = 1'b1;
        if (rl == CNT_ONE) begin
          res.command_bits = i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN
                           | i2cmts_pkg::CMD_START;
          phase_nxt        = PH_RFIN;
        end else begin
          res.command_bits = i2cmts_pkg::CMD_ACK | i2cmts_pkg::CMD_RUN
                           | i2cmts_pkg::CMD_START;
          phase_nxt        = PH_RCONT;
        end
      end else begin
        res.done_res    = 1'b1;
        res.status      = i2cmts_pkg::ST_DONE;
        res.read_total  = '0;
        phase_nxt       = PH_IDLE;
        writes_left_nxt = '0;
        reads_left_nxt  = '0;
      end
    end else if (phase_r != PH_IDLE && (word.bus_error || word.arbitration_lost)) begin
      res.done_res    = 1'b1;
      res.read_total  = 8'(reads_done_r);
      phase_nxt       = PH_IDLE;
      writes_left_nxt = '0;
      reads_left_nxt  = '0;
      if (word.arbitration_lost) begin
        res.controller_reset = 1'b1;
        res.status           = i2cmts_pkg::ST_ARB_LOST;
      end else begin
        if (phase_r != PH_WFIN && phase_r != PH_RFIN) begin
          res.command_valid = 1'b1;
          res.command_bits  = i2cmts_pkg::CMD_STOP;
        end
        if (word.address_nack) begin
          res.status = i2cmts_pkg::ST_ADDR_NACK;
        end else if (word.data_nack) begin
          res.status = i2cmts_pkg::ST_DATA_NACK;
        end else begin
          res.status = i2cmts_pkg::ST_BUS_ERR;
        end
      end
    end else begin
      case (phase_r)
        PH_WCONT: begin
          res.data_valid    = 1'b1;
          res.data_byte     = word.next_write_byte;
          wl                = writes_left_r - CNT_ONE;
          writes_left_nxt   = wl;
          res.command_valid = 1'b1;
          if (wl != '0) begin
            res.command_bits = i2cmts_pkg::CMD_RUN;
            phase_nxt        = PH_WCONT;
          end else if (reads_left_r == '0) begin
            res.command_bits = i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN;
            phase_nxt        = PH_WFIN;
          end else begin
            res.command_bits = i2cmts_pkg::CMD_RUN;
            phase_nxt        = PH_RSTART;
          end
        end
        PH_WFIN: begin
          res.done_res    = 1'b1;
          res.status      = i2cmts_pkg::ST_DONE;
          res.read_total  = 8'(reads_done_r);
          phase_nxt       = PH_IDLE;
          writes_left_nxt = '0;
          reads_left_nxt  = '0;
        end
        PH_RSTART: begin
          extra             = i2cmts_pkg::CMD_START;
          res.address_valid = 1'b1;
          res.address_byte  = {slave_address_r, i2cmts_pkg::ADDR_READ_BIT};
          res.command_valid = 1'b1;
          if (reads_left_r == CNT_ONE) begin
            res.command_bits = i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN | extra;
            phase_nxt        = PH_RFIN;
          end else begin
            res.command_bits = i2cmts_pkg::CMD_ACK | i2cmts_pkg::CMD_RUN | extra;
            phase_nxt        = PH_RCONT;
          end
        end
        PH_RCONT: begin
          res.read_valid    = 1'b1;
          res.read_byte     = word.received_byte;
          reads_done_nxt    = reads_done_r + CNT_ONE;
          rl                = reads_left_r - CNT_ONE;
          reads_left_nxt    = rl;
          res.command_valid = 1'b1;
          if (rl == CNT_ONE) begin
            res.command_bits = i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN;
            phase_nxt        = PH_RFIN;
          end else begin
            res.command_bits = i2cmts_pkg::CMD_ACK | i2cmts_pkg::CMD_RUN;
            phase_nxt        = PH_RCONT;
          end
        end
        PH_RFIN: begin
          res.read_valid  = 1'b1;
          res.read_byte   = word.received_byte;
          rd              = reads_done_r + CNT_ONE;
          reads_done_nxt  = rd;
          res.done_res    = 1'b1;
          res.status      = i2cmts_pkg::ST_DONE;
          res.read_total  = 8'(rd);
          phase_nxt       = PH_IDLE;
          writes_left_nxt = '0;
          reads_left_nxt  = '0;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      slave_address_r <= '0;
      writes_left_r   <= '0;
      reads_left_r    <= '0;
      reads_done_r    <= '0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      slave_address_r <= slave_address_nxt;
      writes_left_r   <= writes_left_nxt;
      reads_left_r    <= reads_left_nxt;
      reads_done_r    <= reads_done_nxt;
    end
  end

  a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.done_res |=> phase_r == PH_IDLE)
    else $error("done reported without returning to idle");

  a_read_counts: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.read_valid |=> reads_done_r == $past(reads_done_r) + CNT_ONE)
    else $error("read byte delivered without count advance");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> writes_left_r == '0 && reads_left_r == '0)
    else $error("counts left over in idle");

  a_rcont_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RCONT |-> reads_left_r > CNT_ONE)
    else $error("read continue with fewer than two bytes left");

endmodule

@@ hdl/i2cmts_out_reg.sv @@
`timescale 1ns / 1ps

module i2cmts_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  i2cmts_pkg::out_word_t res,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2cmts_pkg::out_word_t word_r
);

  logic valid_r;
  logic valid_nxt;

  assign up_ready  = !valid_r || out_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;
  assign out_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= res;
    end
  end

endmodule

@@ hdl/i2c_master_transfer_sequencer_unit.sv @@
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready  | action, target_address, counts, write byte, flags, rx byte
// out     | out_valid / out_ready| command, address, data, read, done/status, controller reset
//
// One word per cycle sustained while the output is not stalled; each word is held in the input
// register and then in the output register.
// Transfer state updates as a word moves from the input to the output register.
// Synchronous active-low reset returns the sequencer to idle with empty registers.
// A stalled output holds its word; the input register still takes one more word.

module i2c_master_transfer_sequencer_unit #(
  parameter int COUNT_BITS = i2cmts_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_action,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_write_count,
  input  logic [7:0] in_read_count,
  input  logic [7:0] in_next_write_byte,
  input  logic       in_bus_error,
  input  logic       in_arbitration_lost,
  input  logic       in_address_nack,
  input  logic       in_data_nack,
  input  logic [7:0] in_received_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_command_valid,
  output logic [3:0] out_command_bits,
  output logic       out_address_valid,
  output logic [7:0] out_address_byte,
  output logic       out_data_valid,
  output logic [7:0] out_data_byte,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_done_res,
  output logic [2:0] out_status,
  output logic [7:0] out_read_total,
  output logic       out_controller_reset
);

  i2cmts_pkg::in_word_t  in_word;
  i2cmts_pkg::in_word_t  stage_word;
  i2cmts_pkg::out_word_t res;
  i2cmts_pkg::out_word_t out_word;
  i2cmts_pkg::hs_t       stage_hs;
  logic                  down_ready;

  assign in_word.action           = in_action;
  assign in_word.target_address   = in_target_address;
  assign in_word.write_count      = in_write_count;
  assign in_word.read_count       = in_read_count;
  assign in_word.next_write_byte  = in_next_write_byte;
  assign in_word.bus_error        = in_bus_error;
  assign in_word.arbitration_lost = in_arbitration_lost;
  assign in_word.address_nack     = in_address_nack;
  assign in_word.data_nack        = in_data_nack;
  assign in_word.received_byte    = in_received_byte;

  i2cmts_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .down_ready (down_ready),
    .hs         (stage_hs),
    .word_r     (stage_word)
  );

  i2cmts_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (stage_hs.valid && stage_hs.ready),
    .word  (stage_word),
    .res   (res)
  );

  i2cmts_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stage_hs.valid),
    .up_ready  (down_ready),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .word_r    (out_word)
  );

  assign out_command_valid    = out_word.command_valid;
  assign out_command_bits     = out_word.command_bits;
  assign out_address_valid    = out_word.address_valid;
  assign out_address_byte     = out_word.address_byte;
  assign out_data_valid       = out_word.data_valid;
  assign out_data_byte        = out_word.data_byte;
  assign out_read_valid       = out_word.read_valid;
  assign out_read_byte        = out_word.read_byte;
  assign out_done_res         = out_word.done_res;
  assign out_status           = out_word.status;
  assign out_read_total       = out_word.read_total;
  assign out_controller_reset = out_word.controller_reset;

endmodule

@@ dv/i2c_master_transfer_sequencer_unit_tb.sv @@
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_unit_tb;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int MAX_PRINTS     = 40;
  localparam int PHASE_WORDS    = 200;

  typedef enum logic [2:0] {
    PH_IDLE, PH_WR_MORE, PH_WR_LAST, PH_RD_BEGIN, PH_RD_MORE, PH_RD_LAST
  } xfer_phase_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_action = 1'b0;
  logic [6:0] in_target_address = '0;
  logic [7:0] in_write_count = '0;
  logic [7:0] in_read_count = '0;
  logic [7:0] in_next_write_byte = '0;
  logic       in_bus_error = 1'b0;
  logic       in_arbitration_lost = 1'b0;
  logic       in_address_nack = 1'b0;
  logic       in_data_nack = 1'b0;
  logic [7:0] in_received_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_command_valid;
  logic [3:0] out_command_bits;
  logic       out_address_valid;
  logic [7:0] out_address_byte;
  logic       out_data_valid;
  logic [7:0] out_data_byte;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_done_res;
  logic [2:0] out_status;
  logic [7:0] out_read_total;
  logic       out_controller_reset;

  i2cmts_pkg::in_word_t  pending_words[$];
  i2cmts_pkg::out_word_t expected_words[$];
  i2cmts_pkg::in_word_t  cur_word;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          idle_tab[4] = '{0, 71, 0, 25};
  int          stall_tab[4] = '{0, 0, 71, 25};

  xfer_phase_t xfer_phase = PH_IDLE;
  logic [6:0]  slave_addr = '0;
  logic [7:0]  writes_left = '0;
  logic [7:0]  reads_left = '0;
  logic [7:0]  reads_done = '0;

  i2c_master_transfer_sequencer_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_target_address   (in_target_address),
    .in_write_count      (in_write_count),
    .in_read_count       (in_read_count),
    .in_next_write_byte  (in_next_write_byte),
    .in_bus_error        (in_bus_error),
    .in_arbitration_lost (in_arbitration_lost),
    .in_address_nack     (in_address_nack),
    .in_data_nack        (in_data_nack),
    .in_received_byte    (in_received_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_command_valid   (out_command_valid),
    .out_command_bits    (out_command_bits),
    .out_address_valid   (out_address_valid),
    .out_address_byte    (out_address_byte),
    .out_data_valid      (out_data_valid),
    .out_data_byte       (out_data_byte),
    .out_read_valid      (out_read_valid),
    .out_read_byte       (out_read_byte),
    .out_done_res        (out_done_res),
    .out_status          (out_status),
    .out_read_total      (out_read_total),
    .out_controller_reset(out_controller_reset)
  );

  always #2 clk = ~clk;

  // transfer predictor
  function automatic void set_cmd(inout i2cmts_pkg::out_word_t o, input logic [3:0] bits);
    o.command_valid = 1'b1;
    o.command_bits  = bits;
  endfunction

  function automatic void load_address(inout i2cmts_pkg::out_word_t o, input logic rw);
    o.address_valid = 1'b1;
    o.address_byte  = {slave_addr, rw};
  endfunction

  function automatic void load_write(inout i2cmts_pkg::out_word_t o, input logic [7:0] b);
    o.data_valid = 1'b1;
    o.data_byte  = b;
    writes_left  = writes_left - 8'd1;
  endfunction

  function automatic void deliver_read(inout i2cmts_pkg::out_word_t o,
                                       input logic [7:0] b);
    o.read_valid = 1'b1;
    o.read_byte  = b;
    reads_done   = reads_done + 8'd1;
    reads_left   = reads_left - 8'd1;
  endfunction

  function automatic void complete(inout i2cmts_pkg::out_word_t o, input logic [2:0] st);
    o.done_res   = 1'b1;
    o.status     = st;
    o.read_total = reads_done;
    xfer_phase   = PH_IDLE;
    writes_left  = '0;
    reads_left   = '0;
  endfunction

  function automatic void start_read(inout i2cmts_pkg::out_word_t o,
                                     input logic [3:0] extra);
    load_address(o, i2cmts_pkg::ADDR_READ_BIT);
    if (reads_left == 8'd1) begin
      set_cmd(o, i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN | extra);
      xfer_phase = PH_RD_LAST;
    end else begin
      set_cmd(o, i2cmts_pkg::CMD_ACK | i2cmts_pkg::CMD_RUN | extra);
      xfer_phase = PH_RD_MORE;
    end
  endfunction

  function automatic void after_write(inout i2cmts_pkg::out_word_t o,
                                      input logic [3:0] extra);
    if (writes_left != 8'd0) begin
      set_cmd(o, i2cmts_pkg::CMD_RUN | extra);
      xfer_phase = PH_WR_MORE;
    end else if (reads_left == 8'd0) begin
      set_cmd(o, i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN | extra);
      xfer_phase = PH_WR_LAST;
    end else begin
      set_cmd(o, i2cmts_pkg::CMD_RUN | extra);
      xfer_phase = PH_RD_BEGIN;
    end
  endfunction

  function automatic i2cmts_pkg::out_word_t predict_transfer(i2cmts_pkg::in_word_t w);
    i2cmts_pkg::out_word_t o;
    xfer_phase_t           p;
    o = '0;
    if (w.action == i2cmts_pkg::ACT_START) begin
      slave_addr  = w.target_address;
      writes_left = w.write_count;
      reads_left  = w.read_count;
      reads_done  = '0;
      if (writes_left != 8'd0) begin
        load_address(o, i2cmts_pkg::ADDR_WRITE_BIT);
        load_write(o, w.next_write_byte);
        after_write(o, i2cmts_pkg::CMD_START);
      end else if (reads_left != 8'd0) begin
        start_read(o, i2cmts_pkg::CMD_START);
      end else begin
        complete(o, i2cmts_pkg::ST_DONE);
      end
      return o;
    end
    p = xfer_phase;
    if (p == PH_IDLE) return o;
    if (w.bus_error || w.arbitration_lost) begin
      if (w.arbitration_lost) begin
        o.controller_reset = 1'b1;
        complete(o, i2cmts_pkg::ST_ARB_LOST);
      end else begin
        if (p != PH_WR_LAST && p != PH_RD_LAST) set_cmd(o, i2cmts_pkg::CMD_STOP);
        if (w.address_nack) complete(o, i2cmts_pkg::ST_ADDR_NACK);
        else if (w.data_nack) complete(o, i2cmts_pkg::ST_DATA_NACK);
        else complete(o, i2cmts_pkg::ST_BUS_ERR);
      end
      return o;
    end
    case (p)
      PH_WR_MORE: begin
        load_write(o, w.next_write_byte);
        after_write(o, i2cmts_pkg::CMD_NONE);
      end
      PH_WR_LAST: complete(o, i2cmts_pkg::ST_DONE);
      PH_RD_BEGIN: start_read(o, i2cmts_pkg::CMD_START);
      PH_RD_MORE: begin
        deliver_read(o, w.received_byte);
        if (reads_left == 8'd1) begin
          set_cmd(o, i2cmts_pkg::CMD_STOP | i2cmts_pkg::CMD_RUN);
          xfer_phase = PH_RD_LAST;
        end else begin
          set_cmd(o, i2cmts_pkg::CMD_ACK | i2cmts_pkg::CMD_RUN);
          xfer_phase = PH_RD_MORE;
        end
      end
      default: begin
        deliver_read(o, w.received_byte);
        complete(o, i2cmts_pkg::ST_DONE);
      end
    endcase
    return o;
  endfunction

  // stimulus helpers
  function automatic i2cmts_pkg::in_word_t rand_word();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[$bits(i2cmts_pkg::in_word_t)-1:0];
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 2) return 255;
    if (r < 20) return $urandom_range(16, 5);
    return $urandom_range(4, 0);
  endfunction

  task automatic q_start(input logic [6:0] addr, input int wc, input int rc);
    i2cmts_pkg::in_word_t w;
    w = rand_word();
    w.action         = i2cmts_pkg::ACT_START;
    w.target_address = addr;
    w.write_count    = wc[7:0];
    w.read_count     = rc[7:0];
    pending_words.push_back(w);
  endtask

  task automatic q_event(input logic be, input logic al, input logic an, input logic dn);
    i2cmts_pkg::in_word_t w;
    w = rand_word();
    w.action           = i2cmts_pkg::ACT_EVENT;
    w.bus_error        = be;
    w.arbitration_lost = al;
    w.address_nack     = an;
    w.data_nack        = dn;
    pending_words.push_back(w);
  endtask

  // one transfer: start plus write_count + read_count events, maybe cut short
  task automatic add_transfer(inout int added);
    int                   wc;
    int                   rc;
    int                   n;
    int                   cut;
    int                   err_at;
    int                   m;
    int                   kind;
    i2cmts_pkg::in_word_t w;
    if ($urandom_range(99) < 8) begin
      pending_words.push_back(rand_word());
      added++;
    end
    wc = pick_count();
    rc = pick_count();
    n = wc + rc;
    cut = n;
    err_at = -1;
    m = $urandom_range(99);
    if (n > 0 && m < 12) begin
      err_at = $urandom_range(n - 1);
      cut = err_at + 1;
    end else if (n > 0 && m < 20) begin
      cut = $urandom_range(n - 1);
    end
    q_start(7'($urandom_range(127)), wc, rc);
    for (int i = 0; i < cut; i++) begin
      w = rand_word();
      w.action           = i2cmts_pkg::ACT_EVENT;
      w.bus_error        = 1'b0;
      w.arbitration_lost = 1'b0;
      if (i == err_at) begin
        kind = $urandom_range(2);
        w.bus_error        = (kind != 1);
        w.arbitration_lost = (kind != 0);
      end
      pending_words.push_back(w);
    end
    added += cut + 1;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0);
  endtask

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0h expected %0h", name, got, want));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(predict_transfer(cur_word));
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = pending_words.pop_front();
          in_action           <= cur_word.action;
          in_target_address   <= cur_word.target_address;
          in_write_count      <= cur_word.write_count;
          in_read_count       <= cur_word.read_count;
          in_next_write_byte  <= cur_word.next_write_byte;
          in_bus_error        <= cur_word.bus_error;
          in_arbitration_lost <= cur_word.arbitration_lost;
          in_address_nack     <= cur_word.address_nack;
          in_data_nack        <= cur_word.data_nack;
          in_received_byte    <= cur_word.received_byte;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    i2cmts_pkg::out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_error("result word with none expected");
        end else begin
          want = expected_words.pop_front();
          check_field("command_valid", 8'(out_command_valid), 8'(want.command_valid));
          check_field("command_bits", 8'(out_command_bits), 8'(want.command_bits));
          check_field("address_valid", 8'(out_address_valid), 8'(want.address_valid));
          check_field("address_byte", out_address_byte, want.address_byte);
          check_field("data_valid", 8'(out_data_valid), 8'(want.data_valid));
          check_field("data_byte", out_data_byte, want.data_byte);
          check_field("read_valid", 8'(out_read_valid), 8'(want.read_valid));
          check_field("read_byte", out_read_byte, want.read_byte);
          check_field("done_res", 8'(out_done_res), 8'(want.done_res));
          check_field("status", 8'(out_status), 8'(want.status));
          check_field("read_total", out_read_total, want.read_total);
          check_field("controller_reset", 8'(out_controller_reset),
                      8'(want.controller_reset));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int added;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed
    pending_words.push_back(i2cmts_pkg::in_word_t'('1));  // event while idle
    pending_words.push_back(i2cmts_pkg::in_word_t'('0));  // empty request
    q_start(7'h7f, 0, 0);
    q_start(7'h00, 1, 0);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_start(7'h55, 0, 1);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_start(7'h2a, 1, 2);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_start(7'h7f, 255, 255);
    q_event(1'b0, 1'b0, 1'b1, 1'b1);
    q_event(1'b0, 1'b1, 1'b0, 1'b0);  // lost arbitration
    q_start(7'h11, 2, 0);
    q_event(1'b1, 1'b0, 1'b1, 1'b0);  // address nack
    q_start(7'h22, 1, 0);
    q_event(1'b1, 1'b0, 1'b0, 1'b1);  // data nack on last byte, stop already sent
    q_start(7'h33, 0, 3);
    q_event(1'b0, 1'b0, 1'b0, 1'b0);
    q_event(1'b1, 1'b0, 1'b0, 1'b0);  // plain bus error
    q_start(7'h44, 3, 1);
    q_start(7'h45, 0, 0);             // restart while busy
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      added = 0;
      while (added < PHASE_WORDS) add_transfer(added);
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ i2c_master_transfer_sequencer_unit.f @@
hdl/i2cmts_pkg.sv
hdl/i2cmts_in_reg.sv
hdl/i2cmts_core.sv
hdl/i2cmts_out_reg.sv
hdl/i2c_master_transfer_sequencer_unit.sv
dv/i2c_master_transfer_sequencer_unit_tb.sv
